FILE: sv/fiolw_pkg.sv
// Shared types and constants for the framed IO link with watchdog.
package fiolw_pkg;

    localparam logic [7:0] HEAD_BYTE = 8'hAA;
    localparam logic [7:0] TAIL_BYTE = 8'h55;

    localparam logic [15:0] TIMEOUT_RESET = 16'd500;
    localparam logic [15:0] PERIOD_RESET  = 16'd50;
    localparam logic [7:0]  CODE_RESET    = 8'h01;
    localparam logic [15:0] COUNT_MAX     = 16'hFFFF;

    localparam int FRAME_BYTES = 6;

    typedef enum logic [1:0] {
        ACT_BYTE = 2'd0,
        ACT_TICK = 2'd1,
        ACT_SAFE = 2'd2,
        ACT_NONE = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        REG_TIMEOUT = 2'd0,
        REG_PERIOD  = 2'd1,
        REG_CODE    = 2'd2,
        REG_UNUSED  = 2'd3
    } reg_index_t;

    // Result of the command frame parser for one byte.
    typedef struct packed {
        logic       ok;
        logic [7:0] map;
    } rx_result_t;

    // Contents handed to the status frame sender on a report tick.
    typedef struct packed {
        logic [7:0] code;
        logic [7:0] pins_inv;
        logic [7:0] drive;
    } tx_load_t;

endpackage

FILE: sv/fiolw_rx.sv
// Command frame parser: hunts for head, collects bytes, checks sum and tail.
module fiolw_rx
    import fiolw_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       strobe,
    input  logic [7:0] rx_byte,
    output rx_result_t result
);

    logic [2:0] pos_reg;
    logic [2:0] pos_next;
    logic [7:0] bytes_reg [5];
    logic [7:0] sum;
    logic       frame_end;

    assign frame_end = (pos_reg >= 3'd5);
    assign sum = bytes_reg[0] + bytes_reg[1] + bytes_reg[2] + bytes_reg[3];

    always_comb
    begin
        pos_next = pos_reg;
        if (strobe)
        begin
            if (pos_reg == 3'd0)
            begin
                if (rx_byte == HEAD_BYTE)
                begin
                    pos_next = 3'd1;
                end
            end
            else if (!frame_end)
            begin
                pos_next = pos_reg + 3'd1;
            end
            else
            begin
                pos_next = 3'd0;
            end
        end
    end

    assign result.ok  = strobe && frame_end && (sum == bytes_reg[4]) && (rx_byte == TAIL_BYTE);
    assign result.map = bytes_reg[2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= 3'd0;
        end
        else
        begin
            pos_reg <= pos_next;
        end
    end

    // Frame bytes carry no reset; an unwritten slot is never read.
    always_ff @(posedge clk)
    begin
        if (strobe && !frame_end)
        begin
            if (pos_reg != 3'd0 || rx_byte == HEAD_BYTE)
            begin
                bytes_reg[pos_reg] <= rx_byte;
            end
        end
    end

endmodule

FILE: sv/fiolw_tx.sv
// Status frame sender: holds one frame and plays it out a beat at a time.
module fiolw_tx
    import fiolw_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        load,
    input  tx_load_t    load_data,
    output logic        can_load,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] tx_byte, [15:8] output_drive
    output logic        m_tlast
);

    localparam logic [2:0] LAST_IDX = 3'(FRAME_BYTES - 1);

    logic       busy_reg;
    logic       busy_next;
    logic [2:0] idx_reg;
    logic [2:0] idx_next;
    tx_load_t   data_reg;
    logic [7:0] sum_reg;
    logic [7:0] tx_byte;
    logic       take;

    assign take     = busy_reg && m_tready;
    assign m_tlast  = busy_reg && (idx_reg == LAST_IDX);
    assign can_load = !busy_reg || (take && idx_reg == LAST_IDX);

    always_comb
    begin
        busy_next = busy_reg;
        idx_next  = idx_reg;
        if (take)
        begin
            if (idx_reg == LAST_IDX)
            begin
                busy_next = 1'b0;
                idx_next  = 3'd0;
            end
            else
            begin
                idx_next = idx_reg + 3'd1;
            end
        end
        if (load)
        begin
            busy_next = 1'b1;
            idx_next  = 3'd0;
        end
    end

    always_comb
    begin
        case (idx_reg)
            3'd0:    tx_byte = HEAD_BYTE;
            3'd1:    tx_byte = data_reg.code;
            3'd2:    tx_byte = 8'h00;
            3'd3:    tx_byte = data_reg.pins_inv;
            3'd4:    tx_byte = sum_reg;
            default: tx_byte = TAIL_BYTE;
        endcase
    end

    assign m_tvalid = busy_reg;
    assign m_tdata  = {data_reg.drive, tx_byte};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= 3'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= load_data;
            sum_reg  <= HEAD_BYTE + load_data.code + load_data.pins_inv;
        end
    end

endmodule

FILE: sv/framed_io_link_with_watchdog_core.sv
// Top level: item register, watchdog and report logic, status frame output.
// An item is registered, then processed from the item register; a report tick loads
//   the status frame sender, which then sends one beat per cycle while m_tready is high.
// Throughput: one input beat per cycle; a report tick waits only for the previous
//   six-beat status frame to drain.
// Reset (rst_n, async active low): registers 500/50/1, parser hunting, map and
//   counters zero, pending flag set, no status frame in flight.
module framed_io_link_with_watchdog_core
    import fiolw_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [7:0] rx_byte, [15:8] input_pins
    input  logic [1:0]  s_tuser,   // [1:0] action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] tx_byte, [15:8] output_drive
    output logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [15:0] timeout_reg;
    logic [15:0] period_reg;
    logic [7:0]  code_reg;

    logic        in_valid_reg;
    action_t     act_reg;
    logic [7:0]  rx_reg;
    logic [7:0]  pins_reg;

    logic [7:0]  pending_map_reg;
    logic [7:0]  pending_map_next;
    logic        pending_flag_reg;
    logic        pending_flag_next;
    logic [15:0] since_reg;
    logic [15:0] since_next;
    logic [15:0] period_cnt_reg;
    logic [15:0] period_cnt_next;
    logic [7:0]  applied_reg;
    logic [7:0]  applied_next;

    logic [15:0] since_inc;
    logic [15:0] period_inc;
    logic        is_tick;
    logic        is_report;
    logic        proc_fire;
    logic        tx_can_load;
    rx_result_t  rx_res;
    tx_load_t    tx_data;
    reg_index_t  cfg_idx;
    logic        cfg_write;

    // ---------------- configuration port ----------------
    assign pready    = 1'b1;
    assign cfg_idx   = reg_index_t'(paddr[3:2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        case (cfg_idx)
            REG_TIMEOUT: prdata = {16'd0, timeout_reg};
            REG_PERIOD:  prdata = {16'd0, period_reg};
            REG_CODE:    prdata = {24'd0, code_reg};
            default:     prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= TIMEOUT_RESET;
            period_reg  <= PERIOD_RESET;
            code_reg    <= CODE_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_idx)
                REG_TIMEOUT: timeout_reg <= pwdata[15:0];
                REG_PERIOD:  period_reg  <= pwdata[15:0];
                REG_CODE:    code_reg    <= pwdata[7:0];
                default:     ;
            endcase
        end
    end

    // ---------------- item register ----------------
    assign is_tick    = in_valid_reg && (act_reg == ACT_TICK);
    assign since_inc  = (since_reg == COUNT_MAX) ? since_reg : since_reg + 16'd1;
    assign period_inc = (period_cnt_reg == COUNT_MAX) ? period_cnt_reg
                                                      : period_cnt_reg + 16'd1;
    assign is_report  = is_tick && (period_inc >= period_reg);
    // A report only stalls when the previous status frame is still draining.
    assign proc_fire  = in_valid_reg && (!is_report || tx_can_load);
    assign s_tready   = !in_valid_reg || proc_fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            act_reg  <= action_t'(s_tuser);
            rx_reg   <= s_tdata[7:0];
            pins_reg <= s_tdata[15:8];
        end
    end

    fiolw_rx u_rx
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .strobe  (proc_fire && act_reg == ACT_BYTE),
        .rx_byte (rx_reg),
        .result  (rx_res)
    );

    // ---------------- watchdog and report ----------------
    always_comb
    begin
        pending_map_next  = pending_map_reg;
        pending_flag_next = pending_flag_reg;
        since_next        = since_reg;
        period_cnt_next   = period_cnt_reg;
        applied_next      = applied_reg;
        if (proc_fire)
        begin
            case (act_reg)
                ACT_BYTE:
                begin
                    if (rx_res.ok)
                    begin
                        pending_map_next  = rx_res.map;
                        pending_flag_next = 1'b1;
                        since_next        = 16'd0;
                    end
                end
                ACT_SAFE:
                begin
                    pending_map_next  = 8'd0;
                    pending_flag_next = 1'b1;
                    since_next        = 16'd0;
                end
                ACT_TICK:
                begin
                    since_next      = since_inc;
                    period_cnt_next = period_inc;
                    if (is_report)
                    begin
                        period_cnt_next   = 16'd0;
                        pending_flag_next = 1'b0;
                        if (pending_flag_reg)
                        begin
                            applied_next = pending_map_reg;
                        end
                        if (since_inc > timeout_reg)
                        begin
                            applied_next = 8'd0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_map_reg  <= 8'd0;
            pending_flag_reg <= 1'b1;
            since_reg        <= 16'd0;
            period_cnt_reg   <= 16'd0;
            applied_reg      <= 8'd0;
        end
        else
        begin
            pending_map_reg  <= pending_map_next;
            pending_flag_reg <= pending_flag_next;
            since_reg        <= since_next;
            period_cnt_reg   <= period_cnt_next;
            applied_reg      <= applied_next;
        end
    end

    assign tx_data.code     = code_reg;
    assign tx_data.pins_inv = ~pins_reg;
    assign tx_data.drive    = ~applied_next;

    fiolw_tx u_tx
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (proc_fire && is_report),
        .load_data (tx_data),
        .can_load  (tx_can_load),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

`ifndef ASSERT_OFF
    // A new status frame never overwrites beats still waiting to go out.
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (proc_fire && is_report) |-> (!m_tvalid || (m_tready && m_tlast)))
        else $error("status frame loaded over an undelivered frame");

    // Every report consumes the pending map.
    a_flag_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (proc_fire && is_report) |=> !pending_flag_reg)
        else $error("pending flag survived a report");

    // Output drive is constant within one status frame.
    a_drive_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && !m_tlast) |=>
        (m_tvalid && m_tdata[15:8] == $past(m_tdata[15:8])))
        else $error("output drive changed inside a status frame");
`endif

endmodule

FILE: tb/framed_io_link_with_watchdog_core_tb.sv
// Testbench for the framed IO link with watchdog: random and directed traffic, scoreboard check.
`timescale 1ns / 100ps

module framed_io_link_with_watchdog_core_tb
    import fiolw_pkg::*;
();

    localparam int FRAME_OK       = 0;
    localparam int FRAME_BAD_SUM  = 1;
    localparam int FRAME_BAD_TAIL = 2;
    localparam int FRAME_CUT      = 3;

    localparam int SETTLE_CYCLES = 8;

    typedef struct {
        logic [7:0] tx_byte;
        logic       last;
        logic [7:0] drive;
    } status_beat_t;

    // Predicts status beats from accepted input beats and checks what comes out.
    class io_link_model;
        logic [15:0]  timeout_ms;
        logic [15:0]  period_ms;
        logic [7:0]   status_code;
        logic [2:0]   cmd_pos;
        logic [7:0]   cmd_bytes [5];
        logic [7:0]   pending_map;
        logic         pending_set;
        logic [15:0]  ms_since_cmd;
        logic [15:0]  ms_in_period;
        logic [7:0]   applied_map;
        status_beat_t beats_due [$];
        int           errors;

        function new();
            timeout_ms   = TIMEOUT_RESET;
            period_ms    = PERIOD_RESET;
            status_code  = CODE_RESET;
            cmd_pos      = '0;
            foreach (cmd_bytes[i])
                cmd_bytes[i] = '0;
            pending_map  = '0;
            pending_set  = 1'b1;
            ms_since_cmd = '0;
            ms_in_period = '0;
            applied_map  = '0;
            errors       = 0;
        endfunction

        function void set_register(reg_index_t idx, logic [31:0] value);
            case (idx)
                REG_TIMEOUT: timeout_ms  = value[15:0];
                REG_PERIOD:  period_ms   = value[15:0];
                REG_CODE:    status_code = value[7:0];
                default: ;
            endcase
        endfunction

        function void take_rx_byte(logic [7:0] rx);
            logic [7:0] sum;
            if (cmd_pos == 3'd0)
            begin
                if (rx == HEAD_BYTE)
                begin
                    cmd_bytes[0] = rx;
                    cmd_pos = 3'd1;
                end
            end
            else if (cmd_pos < 3'd5)
            begin
                cmd_bytes[cmd_pos] = rx;
                cmd_pos = cmd_pos + 3'd1;
            end
            else
            begin
                sum = cmd_bytes[0] + cmd_bytes[1] + cmd_bytes[2] + cmd_bytes[3];
                if (sum == cmd_bytes[4] && rx == TAIL_BYTE)
                begin
                    pending_map  = cmd_bytes[2];
                    pending_set  = 1'b1;
                    ms_since_cmd = '0;
                end
                cmd_pos = 3'd0;
            end
        endfunction

        function void note_item(action_t act, logic [7:0] rx, logic [7:0] pins);
            logic [7:0]   frame [FRAME_BYTES];
            status_beat_t beat;
            case (act)
                ACT_BYTE: take_rx_byte(rx);
                ACT_SAFE:
                begin
                    pending_map  = '0;
                    pending_set  = 1'b1;
                    ms_since_cmd = '0;
                end
                ACT_TICK:
                begin
                    if (ms_since_cmd != COUNT_MAX)
                        ms_since_cmd++;
                    if (ms_in_period != COUNT_MAX)
                        ms_in_period++;
                    if (ms_in_period >= period_ms)
                    begin
                        ms_in_period = '0;
                        if (pending_set)
                        begin
                            applied_map = pending_map;
                            pending_set = 1'b0;
                        end
                        if (ms_since_cmd > timeout_ms)
                            applied_map = '0;
                        frame[0] = HEAD_BYTE;
                        frame[1] = status_code;
                        frame[2] = 8'h00;
                        frame[3] = ~pins;
                        frame[4] = frame[0] + frame[1] + frame[2] + frame[3];
                        frame[5] = TAIL_BYTE;
                        for (int k = 0; k < FRAME_BYTES; k++)
                        begin
                            beat.tx_byte = frame[k];
                            beat.last    = (k == FRAME_BYTES - 1);
                            beat.drive   = ~applied_map;
                            beats_due.push_back(beat);
                        end
                    end
                end
                default: ;
            endcase
        endfunction

        task report(string what);
            if (errors < 40)
                $display("ERROR %0t ns: %s", $time, what);
            errors++;
        endtask

        task check_beat(logic [7:0] tx, logic last, logic [7:0] drive);
            status_beat_t want;
            if (beats_due.size() == 0)
            begin
                report($sformatf("status beat %02h arrived with nothing due", tx));
                return;
            end
            want = beats_due.pop_front();
            if (tx !== want.tx_byte)
                report($sformatf("tx_byte %02h, expected %02h", tx, want.tx_byte));
            if (last !== want.last)
                report($sformatf("tlast %b, expected %b", last, want.last));
            if (drive !== want.drive)
                report($sformatf("output_drive %02h, expected %02h", drive, want.drive));
        endtask
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;   // [7:0] rx_byte, [15:8] input_pins
    logic [1:0]  s_tuser;   // [1:0] action
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;   // [7:0] tx_byte, [15:8] output_drive
    logic        m_tlast;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    io_link_model link;
    int           idle_pct = 0;
    int           stall_pct = 0;
    int           hold_request = 0;
    int           hold_left = 0;
    int           sender_idle [4] = '{0, 62, 0, 13};
    int           receiver_stall [4] = '{0, 0, 62, 13};

    framed_io_link_with_watchdog_core DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Sink side: random stalls, plus a long hold-off when one is requested.
    always @(posedge clk)
    begin
        if (hold_request > 0)
        begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= stall_pct);
    end

    // Values read right after the edge are the ones the block sampled at it.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                link.note_item(action_t'(s_tuser), s_tdata[7:0], s_tdata[15:8]);
            if (m_tvalid && m_tready)
                link.check_beat(m_tdata[7:0], m_tlast, m_tdata[15:8]);
        end
    end

    task automatic send_item(action_t act, logic [7:0] rx, logic [7:0] pins);
        int gap;
        gap = 0;
        while ($urandom_range(99) < idle_pct)
            gap++;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {pins, rx};
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    task automatic send_frame(logic [7:0] code, logic [7:0] map, logic [7:0] spare, int fault);
        logic [7:0] frame_bytes [FRAME_BYTES];
        logic [7:0] sum;
        int         n;
        sum = HEAD_BYTE + code + map + spare;
        frame_bytes = '{HEAD_BYTE, code, map, spare, sum, TAIL_BYTE};
        n = FRAME_BYTES;
        case (fault)
            FRAME_BAD_SUM:  frame_bytes[4] = sum ^ 8'($urandom_range(255, 1));
            FRAME_BAD_TAIL: frame_bytes[5] = TAIL_BYTE ^ 8'($urandom_range(255, 1));
            FRAME_CUT:      n = $urandom_range(5, 1);
            default: ;
        endcase
        for (int i = 0; i < n; i++)
            send_item(ACT_BYTE, frame_bytes[i], 8'($urandom_range(255)));
    endtask

    // Drop valid and wait until every predicted beat is out and the pipeline is quiet.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (link.beats_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apb_write(reg_index_t idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        link.set_register(idx, value);
        @(posedge clk);
    endtask

    task automatic random_traffic(int count, int tick_pct);
        int sent;
        int pick;
        sent = 0;
        while (sent < count)
        begin
            pick = $urandom_range(99);
            if (pick < tick_pct)
            begin
                send_item(ACT_TICK, 8'($urandom_range(255)), 8'($urandom_range(255)));
                sent++;
            end
            else
            begin
                pick = $urandom_range(99);
                if (pick < 70)
                begin
                    send_frame(8'($urandom_range(255)), 8'($urandom_range(255)),
                               8'($urandom_range(255)), FRAME_OK);
                    sent += FRAME_BYTES;
                end
                else if (pick < 85)
                begin
                    send_frame(8'($urandom_range(255)), 8'($urandom_range(255)),
                               8'($urandom_range(255)), $urandom_range(FRAME_CUT, FRAME_BAD_SUM));
                    sent += 4;
                end
                else if (pick < 92)
                begin
                    send_item(ACT_SAFE, 8'($urandom_range(255)), 8'($urandom_range(255)));
                    sent++;
                end
                else if (pick < 95)
                    send_item(ACT_NONE, 8'($urandom_range(255)), 8'($urandom_range(255)));
                else
                begin
                    send_item(ACT_BYTE, 8'($urandom_range(255)), 8'($urandom_range(255)));
                    sent++;
                end
            end
        end
    endtask

    initial
    begin
        int mode;
        link     = new();
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = ACT_NONE;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset register values: tick-heavy so the 50 ms report period comes around
        random_traffic(60, 92);
        wait_idle();

        apb_write(REG_PERIOD, 32'd1);
        apb_write(REG_TIMEOUT, 32'd1);
        apb_write(REG_CODE, 32'h00);
        send_item(ACT_TICK, 8'($urandom_range(255)), 8'h00);
        send_frame(8'h00, 8'hFF, 8'h00, FRAME_OK);
        send_item(ACT_TICK, 8'($urandom_range(255)), 8'hFF);
        send_item(ACT_NONE, HEAD_BYTE, 8'h5A);
        send_item(ACT_BYTE, 8'h3C, 8'h00);          // dropped while hunting
        send_frame(8'hFF, 8'h81, 8'hFF, FRAME_BAD_TAIL);
        send_frame(8'h7E, 8'h42, 8'h00, FRAME_BAD_SUM);
        send_item(ACT_TICK, 8'h00, 8'hA5);
        send_item(ACT_TICK, 8'hFF, 8'h0F);          // watchdog past timeout, map forced off
        send_item(ACT_SAFE, 8'hFF, 8'hFF);
        send_item(ACT_TICK, 8'h55, 8'h00);
        wait_idle();

        // zero period: every tick reports
        apb_write(REG_PERIOD, 32'd0);
        apb_write(REG_CODE, 32'hFF);
        repeat (3) send_item(ACT_TICK, 8'($urandom_range(255)), 8'($urandom_range(255)));
        wait_idle();

        for (int ph = 1; ph < 8; ph++)
        begin
            mode = ph % 4;
            idle_pct  = sender_idle[mode];
            stall_pct = receiver_stall[mode];
            case ($urandom_range(3))
                0:       apb_write(REG_TIMEOUT, 32'd1);
                1:       apb_write(REG_TIMEOUT, 32'd65534);
                default: apb_write(REG_TIMEOUT, $urandom_range(12, 2));
            endcase
            if (ph == 2 || $urandom_range(2) == 0)
                apb_write(REG_PERIOD, 32'd1);
            else
                apb_write(REG_PERIOD, $urandom_range(4, 2));
            apb_write(REG_CODE, $urandom_range(255));
            if (ph == 2)
                hold_request = 400;     // sink holds off so the block backs up
            random_traffic(48, 35);
            wait_idle();
        end

        idle_pct  = 0;
        stall_pct = 0;
        repeat (12) @(posedge clk);
        if (link.beats_due.size() != 0)
            link.report($sformatf("%0d status beats never arrived", link.beats_due.size()));
        if (link.errors == 0)
            $display("framed_io_link_with_watchdog_core: match");
        else
            $display("framed_io_link_with_watchdog_core: mismatch");
        $finish;
    end

    initial
    begin
        #(20_000_000);
        $display("framed_io_link_with_watchdog_core: mismatch");
        $finish;
    end

endmodule
